@@ rtl/esi_pkg.sv @@
// ----------------------------------------------------------------------------
// esi_pkg
// Types, codes and helper functions shared by the external memory interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esi_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned BusAddrW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WaitW   = 2;
  localparam int unsigned LimitLowW = 13;

  typedef enum logic [2:0] {
    FUNC_REG_RD  = 3'd0,
    FUNC_REG_WR  = 3'd1,
    FUNC_EXT_RD  = 3'd2,
    FUNC_EXT_WR  = 3'd3,
    FUNC_WAIT_Q  = 3'd4
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CTRL_A_ADDR   = 3'd0,
    CFG_CTRL_B_ADDR   = 3'd1,
    CFG_INTERNAL_END  = 3'd2,
    CFG_ENABLE_MASK   = 3'd3,
    CFG_LIMIT_MASK    = 3'd4,
    CFG_LOWER_WAIT    = 3'd5,
    CFG_UPPER_WAIT    = 3'd6,
    CFG_MCU_PRESENT   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  localparam logic [BusAddrW-1:0] CtrlAAddrRst   = 16'd116;
  localparam logic [BusAddrW-1:0] CtrlBAddrRst   = 16'd109;
  localparam logic [BusAddrW-1:0] InternalEndRst = 16'd4351;
  localparam logic [DataW-1:0]    EnableMaskRst  = 8'h80;
  localparam logic [DataW-1:0]    LimitMaskRst   = 8'h70;
  localparam logic [DataW-1:0]    LowerWaitRst   = 8'h0C;
  localparam logic [DataW-1:0]    UpperWaitRst   = 8'h02;

  // Register field, right aligned to the lowest set bit of its mask.
  function automatic logic [DataW-1:0] field_of(input logic [DataW-1:0] r,
                                                input logic [DataW-1:0] m);
    logic [DataW-1:0] v;
    logic             found;
    v        = r & m;
    found    = 1'b0;
    field_of = '0;
    for (int i = 0; i < DataW; i++) begin
      if (!found && m[i]) begin
        field_of = v >> i;
        found    = 1'b1;
      end
    end
  endfunction

  // Wait field to wait states: 1..3 pass, anything else is 0.
  function automatic logic [WaitW-1:0] wait_map(input logic [DataW-1:0] w);
    wait_map = (w[DataW-1:WaitW] == '0) ? w[WaitW-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

@@ rtl/external_sram_interface_core.sv @@
// ----------------------------------------------------------------------------
// external_sram_interface_core
// External memory interface: control registers, byte store, wait states.
// ----------------------------------------------------------------------------
// Sequencing: an accepted transaction is registered, then executed, and its
//   result is registered and held until taken at the output handshake.
// The byte store is single-port with a registered read; the sequencer holds one
//   transaction at a time, so a new one is accepted only after the last result is taken.
// Reset: clears the sequencer and control registers A and B, and returns the
//   configuration to its defaults; the byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module external_sram_interface_core import esi_pkg::*; #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  [2:0]           func_i,
  input  wire  [BusAddrW-1:0]  address_i,
  input  wire  [DataW-1:0]     write_data_i,
  input  wire  [DataW-1:0]     mcu_ctrl_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [DataW-1:0]     read_data_o,
  output logic [WaitW-1:0]     wait_count_o,
  output logic                 mem_enabled_o,
  output logic                 ext_taken_o,
  input  wire                  cfg_we_i,
  input  wire  [CfgIdxW-1:0]   cfg_index_i,
  input  wire  [CfgDataW-1:0]  cfg_data_i
);

  cmd_t cmd;

  esi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  esi_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .mcu_ctrl_i    (mcu_ctrl_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .read_data_o   (read_data_o),
    .wait_count_o  (wait_count_o),
    .mem_enabled_o (mem_enabled_o),
    .ext_taken_o   (ext_taken_o)
  );

endmodule

`default_nettype wire

@@ rtl/esi_ctrl.sv @@
// ----------------------------------------------------------------------------
// esi_ctrl
// Transaction sequencer: accept, execute, present result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esi_ctrl import esi_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides open together");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd_o.exec)
    else $error("accepted transaction not executed");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (out_valid_o && !in_ready_o))
    else $error("executed transaction has no result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> (in_ready_o && !out_valid_o))
    else $error("no return to idle after result");

endmodule

`default_nettype wire

@@ rtl/esi_datapath.sv @@
// ----------------------------------------------------------------------------
// esi_datapath
// Configuration and control registers, byte store and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esi_datapath import esi_pkg::*; #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  cmd_t                  cmd_i,
  input  wire  [2:0]            func_i,
  input  wire  [BusAddrW-1:0]   address_i,
  input  wire  [DataW-1:0]      write_data_i,
  input  wire  [DataW-1:0]      mcu_ctrl_i,
  input  wire                   cfg_we_i,
  input  wire  [CfgIdxW-1:0]    cfg_index_i,
  input  wire  [CfgDataW-1:0]   cfg_data_i,
  output logic [DataW-1:0]      read_data_o,
  output logic [WaitW-1:0]      wait_count_o,
  output logic                  mem_enabled_o,
  output logic                  ext_taken_o
);

  localparam int unsigned Depth = 2 ** ADDR_BITS;

  logic [BusAddrW-1:0] ctrl_a_addr_q, ctrl_b_addr_q, internal_end_q;
  logic [DataW-1:0]    enable_mask_q, limit_mask_q, lower_wait_q, upper_wait_q;
  logic                mcu_present_q;
  logic [DataW-1:0]    ctrl_a_q, ctrl_b_q;

  logic [2:0]          func_q;
  logic [BusAddrW-1:0] addr_q;
  logic [DataW-1:0]    wdata_q, mcu_q;

  logic [DataW-1:0]    rd_q, mem_rdata_q;
  logic [WaitW-1:0]    wc_q;
  logic                en_q, taken_q, ext_rd_q;

  logic [DataW-1:0]    mem [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_addr_q  <= CtrlAAddrRst;
      ctrl_b_addr_q  <= CtrlBAddrRst;
      internal_end_q <= InternalEndRst;
      enable_mask_q  <= EnableMaskRst;
      limit_mask_q   <= LimitMaskRst;
      lower_wait_q   <= LowerWaitRst;
      upper_wait_q   <= UpperWaitRst;
      mcu_present_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CTRL_A_ADDR:  ctrl_a_addr_q  <= cfg_data_i;
        CFG_CTRL_B_ADDR:  ctrl_b_addr_q  <= cfg_data_i;
        CFG_INTERNAL_END: internal_end_q <= cfg_data_i;
        CFG_ENABLE_MASK:  enable_mask_q  <= cfg_data_i[DataW-1:0];
        CFG_LIMIT_MASK:   limit_mask_q   <= cfg_data_i[DataW-1:0];
        CFG_LOWER_WAIT:   lower_wait_q   <= cfg_data_i[DataW-1:0];
        CFG_UPPER_WAIT:   upper_wait_q   <= cfg_data_i[DataW-1:0];
        CFG_MCU_PRESENT:  mcu_present_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      mcu_q   <= mcu_ctrl_i;
    end
  end

  logic                 en, in_store, ext_ok, hit_a, hit_b;
  logic [DataW-1:0]     srl, wfield;
  logic [BusAddrW-1:0]  limit;
  logic [WaitW-1:0]     wc;
  logic [DataW-1:0]     rd;
  logic                 taken, ctrl_a_we, ctrl_b_we, mem_we;

  always_comb begin
    en       = ((ctrl_a_q & enable_mask_q) != '0) ||
               (mcu_present_q && ((mcu_q & enable_mask_q) != '0));
    in_store = (({16'd0, addr_q} >> ADDR_BITS) == 32'd0);
    ext_ok   = en && in_store && (addr_q > internal_end_q);
    hit_a    = (addr_q == ctrl_a_addr_q);
    hit_b    = (addr_q == ctrl_b_addr_q);
    srl      = field_of(ctrl_a_q, limit_mask_q);
    limit    = (srl == '0) ? '0 : ({srl[2:0], {LimitLowW{1'b0}}} - 16'd1);
    wfield   = (addr_q <= limit) ? field_of(ctrl_a_q, lower_wait_q)
                                 : field_of(ctrl_a_q, upper_wait_q);
    wc        = '0;
    rd        = '0;
    taken     = 1'b0;
    ctrl_a_we = 1'b0;
    ctrl_b_we = 1'b0;
    mem_we    = 1'b0;
    case (func_q)
      FUNC_REG_RD: begin
        if (hit_a) begin
          rd = ctrl_a_q;
        end else if (hit_b) begin
          rd = ctrl_b_q;
        end
      end
      FUNC_REG_WR: begin
        ctrl_a_we = hit_a;
        ctrl_b_we = !hit_a && hit_b;
      end
      FUNC_EXT_RD: begin
        taken = ext_ok;
      end
      FUNC_EXT_WR: begin
        taken  = ext_ok;
        mem_we = ext_ok;
      end
      FUNC_WAIT_Q: begin
        if (en && (addr_q > internal_end_q)) begin
          wc = wait_map(wfield);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      ctrl_b_q <= '0;
    end else if (cmd_i.exec) begin
      if (ctrl_a_we) begin
        ctrl_a_q <= wdata_q;
      end
      if (ctrl_b_we) begin
        ctrl_b_q <= wdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (mem_we) begin
        mem[addr_q[ADDR_BITS-1:0]] <= wdata_q;
      end
      mem_rdata_q <= mem[addr_q[ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q     <= rd;
      wc_q     <= wc;
      en_q     <= en;
      taken_q  <= taken;
      ext_rd_q <= (func_q == FUNC_EXT_RD) && ext_ok;
    end
  end

  assign read_data_o   = ext_rd_q ? mem_rdata_q : rd_q;
  assign wait_count_o  = wc_q;
  assign mem_enabled_o = en_q;
  assign ext_taken_o   = taken_q;

endmodule

`default_nettype wire

@@ tb/sv/external_sram_interface_core_tb.sv @@
// ----------------------------------------------------------------------------
// external_sram_interface_core_tb
// Self-checking bench for the external memory interface. A short table of
// directed transactions covers reset values, gating, boundaries and unused
// function codes. Randomized traffic follows under eight configurations,
// extremes included. Every accepted transaction is run through a local model
// of the control registers, byte store and wait-state logic, and each result
// is compared field by field, in order, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module external_sram_interface_core_tb;
  import esi_pkg::*;

  localparam logic [2:0]  FUNC_RSVD_5   = 3'd5;
  localparam logic [2:0]  FUNC_RSVD_7   = 3'd7;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 210;
  localparam int unsigned LongHold      = 60;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned HoldPhase     = 3;
  localparam int unsigned PausePhase    = 5;

  typedef struct packed {
    logic [2:0]          func;
    logic [BusAddrW-1:0] addr;
    logic [DataW-1:0]    wdata;
    logic [DataW-1:0]    mcu;
  } xact_t;

  typedef struct packed {
    logic [DataW-1:0] rd;
    logic [WaitW-1:0] wc;
    logic             en;
    logic             taken;
  } result_t;

  typedef struct packed {
    logic [BusAddrW-1:0] a_addr;
    logic [BusAddrW-1:0] b_addr;
    logic [BusAddrW-1:0] int_end;
    logic [DataW-1:0]    en_mask;
    logic [DataW-1:0]    lim_mask;
    logic [DataW-1:0]    lo_mask;
    logic [DataW-1:0]    hi_mask;
    logic                present;
  } xmem_cfg_t;

  typedef struct packed {
    xact_t   x;
    logic    fixed;
    result_t res;
  } dir_row_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                out_ready   = 1'b0;
  logic [2:0]          func        = '0;
  logic [BusAddrW-1:0] address     = '0;
  logic [DataW-1:0]    write_data  = '0;
  logic [DataW-1:0]    mcu_ctrl    = '0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  wire                 in_ready;
  wire                 out_valid;
  wire [DataW-1:0]     read_data;
  wire [WaitW-1:0]     wait_count;
  wire                 mem_enabled;
  wire                 ext_taken;

  xmem_cfg_t           cur_cfg;
  logic [DataW-1:0]    reg_a;
  logic [DataW-1:0]    reg_b;
  logic [DataW-1:0]    xmem_image   [0:65535];
  bit                  xmem_written [0:65535];
  logic [BusAddrW-1:0] written_addrs[$];
  result_t             pending_results[$];
  dir_row_t            dir_rows[$];

  bit                  hold_request = 1'b0;
  int unsigned         fail_count   = 0;
  int unsigned         n_results    = 0;
  int unsigned         n_ext_done   = 0;
  int unsigned         n_waits      = 0;
  int unsigned         snd_left     = 0;
  bit                  snd_no_idle  = 1'b0;

  external_sram_interface_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .address_i     (address),
    .write_data_i  (write_data),
    .mcu_ctrl_i    (mcu_ctrl),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .read_data_o   (read_data),
    .wait_count_o  (wait_count),
    .mem_enabled_o (mem_enabled),
    .ext_taken_o   (ext_taken),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- model of the block ----

  function automatic logic [DataW-1:0] field_at(logic [DataW-1:0] r, logic [DataW-1:0] m);
    logic [DataW-1:0] v;
    logic [DataW-1:0] k;
    v = r & m;
    k = m;
    if (m == '0) return '0;
    while (!k[0]) begin
      k = k >> 1;
      v = v >> 1;
    end
    return v;
  endfunction

  function automatic logic xmem_on(logic [DataW-1:0] mcu);
    return ((reg_a & cur_cfg.en_mask) != '0) ||
           (cur_cfg.present && ((mcu & cur_cfg.en_mask) != '0));
  endfunction

  function automatic logic [BusAddrW-1:0] sector_limit();
    logic [31:0] f;
    f = 32'(field_at(reg_a, cur_cfg.lim_mask));
    return (f == 0) ? '0 : 16'((f * 32'h2000) - 32'd1);
  endfunction

  function automatic logic ext_hit(logic en, logic [BusAddrW-1:0] a);
    return en && (a > cur_cfg.int_end);
  endfunction

  function automatic logic [WaitW-1:0] wait_states_for(logic en, logic [BusAddrW-1:0] a);
    logic [DataW-1:0] w;
    if (!en || a <= cur_cfg.int_end) return '0;
    w = (a <= sector_limit()) ? field_at(reg_a, cur_cfg.lo_mask)
                              : field_at(reg_a, cur_cfg.hi_mask);
    return (w <= 8'd3) ? w[WaitW-1:0] : '0;
  endfunction

  function automatic result_t xmem_step(xact_t x);
    result_t r;
    logic    en;
    r    = '0;
    en   = xmem_on(x.mcu);
    r.en = en;
    case (x.func)
      FUNC_REG_RD: begin
        if (x.addr == cur_cfg.a_addr) r.rd = reg_a;
        else if (x.addr == cur_cfg.b_addr) r.rd = reg_b;
      end
      FUNC_REG_WR: begin
        if (x.addr == cur_cfg.a_addr) reg_a = x.wdata;
        else if (x.addr == cur_cfg.b_addr) reg_b = x.wdata;
      end
      FUNC_EXT_RD: begin
        if (ext_hit(en, x.addr)) begin
          r.rd    = xmem_image[x.addr];
          r.taken = 1'b1;
        end
      end
      FUNC_EXT_WR: begin
        if (ext_hit(en, x.addr)) begin
          xmem_image[x.addr] = x.wdata;
          if (!xmem_written[x.addr]) begin
            xmem_written[x.addr] = 1'b1;
            written_addrs = {written_addrs, x.addr};
          end
          r.taken = 1'b1;
        end
      end
      FUNC_WAIT_Q: r.wc = wait_states_for(en, x.addr);
      default: ;
    endcase
    return r;
  endfunction

  // ---- stimulus generation ----

  function automatic logic [BusAddrW-1:0] pick_ext_addr();
    logic [BusAddrW-1:0] e;
    e = cur_cfg.int_end;
    case ($urandom_range(0, 9))
      0: return e;
      1: return e + 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom);
      4: return sector_limit() + 16'($urandom_range(0, 1));
      default: return (e == 16'hFFFF) ? 16'($urandom) : 16'($urandom_range(e + 1, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_mcu();
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: return 8'h00;
      2: return cur_cfg.en_mask | 8'($urandom);
      default: return 8'($urandom) & ~cur_cfg.en_mask;
    endcase
  endfunction

  function automatic logic [BusAddrW-1:0] pick_reg_addr();
    case ($urandom_range(0, 3))
      0, 1: return cur_cfg.a_addr;
      2: return cur_cfg.b_addr;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [BusAddrW-1:0] pick_written();
    return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
  endfunction

  function automatic xact_t gen_xact();
    xact_t       x;
    int unsigned sel;
    x.wdata = 8'($urandom);
    x.mcu   = pick_mcu();
    sel     = $urandom_range(0, 99);
    if (sel < 12) begin
      x.func = FUNC_REG_WR;
      x.addr = pick_reg_addr();
      if ($urandom_range(0, 1) == 1) x.wdata = x.wdata | cur_cfg.en_mask;
    end else if (sel < 24) begin
      x.func = FUNC_REG_RD;
      x.addr = pick_reg_addr();
    end else if (sel < 52) begin
      x.func = FUNC_EXT_WR;
      x.addr = pick_ext_addr();
    end else if (sel < 80) begin
      x.func = FUNC_EXT_RD;
      x.addr = (written_addrs.size() != 0 && $urandom_range(0, 1) == 1) ? pick_written()
                                                                        : pick_ext_addr();
      // a performed read must hit a byte that was written before
      if (ext_hit(xmem_on(x.mcu), x.addr) && !xmem_written[x.addr]) begin
        if (written_addrs.size() == 0) x.func = FUNC_EXT_WR;
        else x.addr = pick_written();
      end
    end else if (sel < 97) begin
      x.func = FUNC_WAIT_Q;
      x.addr = pick_ext_addr();
    end else begin
      x.func = 3'($urandom_range(FUNC_RSVD_5, FUNC_RSVD_7));
      x.addr = 16'($urandom);
    end
    return x;
  endfunction

  function automatic xmem_cfg_t phase_cfg(int unsigned p);
    xmem_cfg_t c;
    case (p)
      0: c = '{CtrlAAddrRst, CtrlBAddrRst, InternalEndRst, EnableMaskRst,
               LimitMaskRst, LowerWaitRst, UpperWaitRst, 1'b1};
      1: c = '{16'h0000, 16'h0000, 16'h0000, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0};
      2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1};
      3: c = '{16'h0038, 16'h0039, 16'h00FF, 8'h00, 8'hF0, 8'h03, 8'h0C, 1'b1};
      default: begin
        c.a_addr   = 16'($urandom);
        c.b_addr   = ($urandom_range(0, 3) == 0) ? c.a_addr : 16'($urandom);
        c.int_end  = 16'($urandom_range(0, 16'hC000));
        c.en_mask  = ($urandom_range(0, 1) == 1) ? 8'(1 << $urandom_range(0, 7))
                                                : 8'($urandom);
        c.lim_mask = 8'($urandom);
        c.lo_mask  = ($urandom_range(0, 1) == 1) ? 8'(3 << $urandom_range(0, 6))
                                                : 8'($urandom);
        c.hi_mask  = ($urandom_range(0, 1) == 1) ? 8'(3 << $urandom_range(0, 6))
                                                : 8'($urandom);
        c.present  = 1'($urandom_range(0, 1));
      end
    endcase
    return c;
  endfunction

  function automatic void add_row(logic [2:0] f, logic [BusAddrW-1:0] a, logic [DataW-1:0] wd,
                                  logic [DataW-1:0] m, logic fx, logic [DataW-1:0] rd,
                                  logic [WaitW-1:0] wc, logic en, logic tk);
    dir_row_t r;
    r.x   = '{f, a, wd, m};
    r.fixed = fx;
    r.res = '{rd, wc, en, tk};
    dir_rows = {dir_rows, r};
  endfunction

  function automatic int unsigned sender_gap();
    if (snd_left == 0) begin
      snd_left    = $urandom_range(20, 80);
      snd_no_idle = ($urandom_range(0, 3) == 0);
    end
    snd_left--;
    return snd_no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // ---- drivers ----

  task automatic offer(xact_t x, logic fx, result_t lit);
    int unsigned gap;
    result_t     pred;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func       <= x.func;
    address    <= x.addr;
    write_data <= x.wdata;
    mcu_ctrl   <= x.mcu;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = xmem_step(x);
    if (fx) pred = lit;
    pending_results = {pending_results, pred};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cfg(xmem_cfg_t c);
    logic [CfgDataW-1:0] d;
    for (int i = 0; i < 8; i++) begin
      case (cfg_reg_e'(i))
        CFG_CTRL_A_ADDR:  d = c.a_addr;
        CFG_CTRL_B_ADDR:  d = c.b_addr;
        CFG_INTERNAL_END: d = c.int_end;
        CFG_ENABLE_MASK:  d = {8'h00, c.en_mask};
        CFG_LIMIT_MASK:   d = {8'h00, c.lim_mask};
        CFG_LOWER_WAIT:   d = {8'h00, c.lo_mask};
        CFG_UPPER_WAIT:   d = {8'h00, c.hi_mask};
        default:          d = {15'h0000, c.present};
      endcase
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_e'(i);
      cfg_data  <= d;
    end
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  // ---- result sink and scoreboard ----

  initial begin : result_sink
    int unsigned gap;
    int unsigned left;
    bit          no_idle;
    result_t     got;
    result_t     want;
    left    = 0;
    no_idle = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = LongHold;
      end else begin
        if (left == 0) begin
          left    = $urandom_range(20, 80);
          no_idle = ($urandom_range(0, 3) == 0);
        end
        left--;
        gap = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {read_data, wait_count, mem_enabled, ext_taken};
      n_results++;
      if (got.taken) n_ext_done++;
      if (got.wc != '0) n_waits++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected result transaction: read_data %h wait_count %0d", got.rd, got.wc);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("mismatch at result %0d (exp/act): read_data %h/%h wait_count %0d/%0d %s",
                     n_results, want.rd, got.rd, want.wc, got.wc,
                     $sformatf("mem_enabled %0b/%0b ext_taken %0b/%0b",
                               want.en, got.en, want.taken, got.taken));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("timeout: no transaction for %0d cycles", IdleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---- main sequence ----

  initial begin : main_seq
    xact_t x;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    cur_cfg = phase_cfg(0);
    reg_a   = '0;
    reg_b   = '0;

    //      func         addr      wd     mcu    fix  rd     wc    en    tk
    add_row(FUNC_REG_RD, 16'd116,  8'h00, 8'h00, 1,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_REG_RD, 16'd109,  8'h00, 8'h00, 1,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_REG_RD, 16'h0000, 8'h00, 8'h7F, 1,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_EXT_RD, 16'hFFFF, 8'h00, 8'h00, 1,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_EXT_WR, 16'hFFFF, 8'hFF, 8'h7F, 1,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_EXT_WR, 16'hFFFF, 8'hA5, 8'h80, 1,   8'h00, 2'd0, 1'b1, 1'b1);
    add_row(FUNC_EXT_RD, 16'hFFFF, 8'h00, 8'hFF, 1,   8'hA5, 2'd0, 1'b1, 1'b1);
    add_row(FUNC_EXT_WR, 16'h10FF, 8'h3C, 8'h80, 1,   8'h00, 2'd0, 1'b1, 1'b0);
    add_row(FUNC_EXT_WR, 16'h1100, 8'h00, 8'h80, 1,   8'h00, 2'd0, 1'b1, 1'b1);
    add_row(FUNC_EXT_RD, 16'h1100, 8'h00, 8'h80, 0,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_EXT_WR, 16'h0000, 8'hFF, 8'hFF, 1,   8'h00, 2'd0, 1'b1, 1'b0);
    add_row(FUNC_WAIT_Q, 16'h8000, 8'h00, 8'h00, 1,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_REG_WR, 16'd116,  8'hFF, 8'h00, 1,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_REG_RD, 16'd116,  8'h00, 8'h00, 1,   8'hFF, 2'd0, 1'b1, 1'b0);
    add_row(FUNC_WAIT_Q, 16'h1100, 8'h00, 8'h00, 0,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_WAIT_Q, 16'hDFFF, 8'h00, 8'h00, 0,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_WAIT_Q, 16'hE000, 8'h00, 8'h00, 0,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_WAIT_Q, 16'hFFFF, 8'h00, 8'h00, 0,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_WAIT_Q, 16'h10FF, 8'h00, 8'h00, 1,   8'h00, 2'd0, 1'b1, 1'b0);
    add_row(FUNC_REG_WR, 16'd109,  8'h5A, 8'h00, 0,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_REG_RD, 16'd109,  8'h00, 8'h00, 0,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_REG_WR, 16'd116,  8'h00, 8'h00, 0,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_EXT_RD, 16'hFFFF, 8'h00, 8'h00, 1,   8'h00, 2'd0, 1'b0, 1'b0);
    add_row(FUNC_RSVD_5, 16'd116,  8'hFF, 8'hFF, 1,   8'h00, 2'd0, 1'b1, 1'b0);
    add_row(FUNC_RSVD_7, 16'hFFFF, 8'h00, 8'h00, 1,   8'h00, 2'd0, 1'b0, 1'b0);

    foreach (dir_rows[i]) offer(dir_rows[i].x, dir_rows[i].fixed, dir_rows[i].res);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain();
      load_cfg(phase_cfg(p));
      for (int unsigned k = 0; k < ItemsPerPhase; k++) begin
        if (p == HoldPhase && k == 40) hold_request = 1'b1;
        if (p == PausePhase && k == 100) drain();
        x = gen_xact();
        offer(x, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      fail_count += pending_results.size();
    end
    $display("covered %0d transactions under %0d configurations: %0d external accesses done,",
             n_results, NumPhases, n_ext_done);
    $display("%0d wait queries with nonzero wait states, %0d failures", n_waits, fail_count);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
